FILE: hw/rtl/buddy_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and idle during reset.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Pool geometry, item types, codes and the memory request/response structs.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int SmallHeight = 7;
  localparam int LargeHeight = 10;
  localparam int MinBlockLog = 5;
  localparam int MaxHeight   = (LargeHeight > SmallHeight) ? LargeHeight : SmallHeight;
  localparam int NodeW       = MaxHeight + 1;
  localparam int LvlW        = $clog2(MaxHeight + 1);
  localparam int MemAw       = NodeW + 1;
  localparam int PowMax      = ((MaxHeight + MinBlockLog) > 16) ? (MaxHeight + MinBlockLog) : 16;
  localparam int PowW        = $clog2(PowMax + 1);
  localparam int CfgIdxW     = 1;

  localparam logic [CfgIdxW-1:0] CfgSmallBase = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLargeBase = 1'b1;

  typedef enum logic [1:0] {
    ActAlloc = 2'd0,
    ActFree  = 2'd1,
    ActInit  = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StZeroSize = 2'd1,
    StNoMem    = 2'd2,
    StOutside  = 2'd3
  } status_e;

  typedef logic [NodeW-1:0] node_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        pool;
    logic [15:0] request_size;
    logic [31:0] address;
  } item_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] block_address;
  } item_out_t;

  typedef struct packed {
    logic [MemAw-1:0] rd_addr;
    logic [MemAw-1:0] bits_waddr;
    logic             bits_we_split;
    logic             bits_we_onl;
    logic             split_wdata;
    logic             onl_wdata;
    logic [MemAw-1:0] link_waddr;
    logic             link_we_prev;
    logic             link_we_next;
    node_t            prev_wdata;
    node_t            next_wdata;
  } mem_req_t;

  typedef struct packed {
    logic  split;
    logic  onl;
    node_t prev;
    node_t next;
  } mem_rsp_t;

  typedef enum logic [4:0] {
    SIdle,
    SDecode,
    SClear,
    SSplit,
    SSplA,
    SSplB,
    SSplC,
    SAfin,
    SFrd,
    SFchk,
    SFbud,
    SFnext,
    SR0,
    SR1,
    SR2,
    SR3,
    SP0,
    SP1,
    SDone
  } seq_state_e;

endpackage

FILE: hw/rtl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Two-pool buddy allocator with allocate, free and pool reinitialize items.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid_i/in_ready_o and carry action, pool, size
// and address; every item produces exactly one result item (status and block
// address) on out_valid_o/out_ready_i. The user must see that pool base
// addresses are written on the cfg port only while the block is idle; the
// block itself does not enforce this. One item is processed at a time.
// Allocate takes longer for every tree level it splits and free for every
// level it coalesces, since every free-list step goes through the single
// read port of the node memories. Reinitializing a pool sweeps its 2048
// node entries, one per cycle. After reset the block sweeps all 4096 node
// entries of both pools, with in_ready_o low, before it takes its first
// item. A finished result sits in an output register; the next item is
// accepted while it waits, and only the completion of that item stalls
// until the receiver takes the earlier result.
module buddy_block_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bba_pkg::item_in_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bba_pkg::item_out_t        out_item_o,
  input  logic                      cfg_we_i,
  input  logic [bba_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]               cfg_wdata_i
);
  import bba_pkg::*;

  `include "buddy_block_allocator_macros.svh"

  logic [31:0] small_base_q, large_base_q;
  logic        out_free, done;
  item_out_t   result, out_item_q;
  logic        out_valid_q;
  logic        out_err;
  mem_req_t    mem_req;
  mem_rsp_t    mem_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_base_q <= '0;
      large_base_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgSmallBase) small_base_q <= cfg_wdata_i;
      if (cfg_index_i == CfgLargeBase) large_base_q <= cfg_wdata_i;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && out_free) out_item_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign out_err     = out_valid_q && (out_item_q.status != StOk);

  bba_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_ready_o   (in_ready_o),
    .small_base_i (small_base_q),
    .large_base_i (large_base_q),
    .out_free_i   (out_free),
    .done_o       (done),
    .result_o     (result),
    .mem_req_o    (mem_req),
    .mem_rsp_i    (mem_rsp)
  );

  bba_mem u_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  `BBA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `BBA_ASSERT(a_error_no_addr, !out_err || (out_item_o.block_address == 32'd0), "error with address")
  `BBA_ASSERT(a_done_not_idle, !(done && in_ready_o), "done while idle")

endmodule

FILE: hw/rtl/bba_mem.sv
// ----------------------------------------------------------------------------
// Buddy allocator node memories
// Split/on-list bits and prev/next list links for both pools, one read port
// with registered data and one write port per memory with field enables.
// ----------------------------------------------------------------------------
module bba_mem (
  input  logic              clk_i,
  input  bba_pkg::mem_req_t req_i,
  output bba_pkg::mem_rsp_t rsp_o
);
  import bba_pkg::*;

  logic [1:0]         bits_mem [2**MemAw];
  logic [2*NodeW-1:0] link_mem [2**MemAw];
  logic [1:0]         bits_rd_q;
  logic [2*NodeW-1:0] link_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.bits_we_split) begin
      bits_mem[req_i.bits_waddr][1] <= req_i.split_wdata;
    end
    if (req_i.bits_we_onl) begin
      bits_mem[req_i.bits_waddr][0] <= req_i.onl_wdata;
    end
    if (req_i.link_we_prev) begin
      link_mem[req_i.link_waddr][2*NodeW-1:NodeW] <= req_i.prev_wdata;
    end
    if (req_i.link_we_next) begin
      link_mem[req_i.link_waddr][NodeW-1:0] <= req_i.next_wdata;
    end
    bits_rd_q <= bits_mem[req_i.rd_addr];
    link_rd_q <= link_mem[req_i.rd_addr];
  end

  assign rsp_o.split = bits_rd_q[1];
  assign rsp_o.onl   = bits_rd_q[0];
  assign rsp_o.prev  = link_rd_q[2*NodeW-1:NodeW];
  assign rsp_o.next  = link_rd_q[NodeW-1:0];

endmodule

FILE: hw/rtl/bba_seq.sv
// ----------------------------------------------------------------------------
// Buddy allocator sequencer
// Decodes one item, walks the tree through the node memories and keeps the
// per-level free list heads of both pools.
// ----------------------------------------------------------------------------
module bba_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  bba_pkg::item_in_t in_item_i,
  output logic              in_ready_o,
  input  logic [31:0]       small_base_i,
  input  logic [31:0]       large_base_i,
  input  logic              out_free_i,
  output logic              done_o,
  output bba_pkg::item_out_t result_o,
  output bba_pkg::mem_req_t mem_req_o,
  input  bba_pkg::mem_rsp_t mem_rsp_i
);
  import bba_pkg::*;

  seq_state_e           state_q, state_d, ret_q, ret_d;
  item_in_t             item_q, item_d;
  node_t                node_q, node_d, cmd_node_q, cmd_node_d;
  node_t                nx_q, nx_d, pv_q, pv_d, hd_q, hd_d;
  logic [LvlW-1:0]      cl_q, cl_d, lvl_q, lvl_d, cmd_lvl_q, cmd_lvl_d;
  logic                 cmd_push_q, cmd_push_d;
  logic [MaxHeight-1:0] pos_q, pos_d;
  logic [MemAw-1:0]     clr_cnt_q, clr_cnt_d;
  logic                 clr_all_q, clr_all_d;
  status_e              status_q, status_d;
  logic [31:0]          baddr_q, baddr_d;

  node_t                heads_q [2][MaxHeight+1];
  logic                 head_we, head_init;
  logic [LvlW-1:0]      head_lvl;
  node_t                head_wdata;

  logic                 pool;
  logic [LvlW-1:0]      height;
  logic [PowW-1:0]      pow_val, k0, k_val;
  logic [15:0]          size_m1;
  logic [LvlW-1:0]      tgt_lvl, c_lvl;
  logic                 found;
  logic [31:0]          base, off, blk_off;
  logic                 outside;
  node_t                free_node, cur_head, buddy;
  logic                 clr_last;

  always_comb begin
    pool    = item_q.pool;
    height  = pool ? LvlW'(LargeHeight) : LvlW'(SmallHeight);
    pow_val = PowW'(height) + PowW'(MinBlockLog);
    base    = pool ? large_base_i : small_base_i;
    size_m1 = item_q.request_size - 16'd1;
    k0      = '0;
    for (int i = 0; i < 16; i++) begin
      if (size_m1[i]) k0 = PowW'(i + 1);
    end
    k_val   = (k0 < PowW'(MinBlockLog)) ? PowW'(MinBlockLog) : k0;
    tgt_lvl = LvlW'(pow_val - k_val);
    // Nearest level at or above the target (toward the root) with a free block.
    found = 1'b0;
    c_lvl = '0;
    for (int i = 0; i <= MaxHeight; i++) begin
      if ((LvlW'(i) <= tgt_lvl) && (heads_q[pool][i] != '0)) begin
        found = 1'b1;
        c_lvl = LvlW'(i);
      end
    end
    off       = item_q.address - base;
    outside   = (item_q.address < base) || ((off >> pow_val) != 32'd0);
    free_node = (node_t'(1) << lvl_q) | node_t'(pos_q);
    buddy     = node_q ^ node_t'(1);
    cur_head  = heads_q[pool][cmd_lvl_q];
    blk_off   = {{(32-NodeW){1'b0}}, node_q & ~(node_t'(1) << lvl_q)} << (pow_val - PowW'(lvl_q));
    clr_last  = (&clr_cnt_q[NodeW-1:0]) && (!clr_all_q || clr_cnt_q[NodeW]);
  end

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    item_d     = item_q;
    node_d     = node_q;
    cmd_node_d = cmd_node_q;
    cmd_lvl_d  = cmd_lvl_q;
    cmd_push_d = cmd_push_q;
    nx_d       = nx_q;
    pv_d       = pv_q;
    hd_d       = hd_q;
    cl_d       = cl_q;
    lvl_d      = lvl_q;
    pos_d      = pos_q;
    clr_cnt_d  = clr_cnt_q;
    clr_all_d  = clr_all_q;
    status_d   = status_q;
    baddr_d    = baddr_q;
    head_we    = 1'b0;
    head_init  = 1'b0;
    head_lvl   = cmd_lvl_q;
    head_wdata = '0;
    in_ready_o = 1'b0;
    done_o     = 1'b0;
    mem_req_o  = '0;
    mem_req_o.rd_addr    = {pool, cmd_node_q};
    mem_req_o.bits_waddr = {pool, cmd_node_q};
    mem_req_o.link_waddr = {pool, cmd_node_q};

    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d   = in_item_i;
          status_d = StOk;
          baddr_d  = '0;
          state_d  = SDecode;
        end
      end
      SDecode: begin
        unique case (action_e'(item_q.action))
          ActAlloc: begin
            if (item_q.request_size == 16'd0) begin
              status_d = StZeroSize;
              state_d  = SDone;
            end else if ((k_val > pow_val) || !found) begin
              status_d = StNoMem;
              state_d  = SDone;
            end else begin
              node_d  = heads_q[pool][c_lvl];
              cl_d    = c_lvl;
              lvl_d   = tgt_lvl;
              state_d = SSplit;
            end
          end
          ActFree: begin
            if (item_q.address == 32'd0) begin
              state_d = SDone;
            end else if (outside) begin
              status_d = StOutside;
              state_d  = SDone;
            end else begin
              lvl_d   = height;
              pos_d   = off[MinBlockLog +: MaxHeight];
              state_d = SFrd;
            end
          end
          ActInit: begin
            clr_cnt_d = {pool, {NodeW{1'b0}}};
            clr_all_d = 1'b0;
            head_init = 1'b1;
            state_d   = SClear;
          end
          ActNone: state_d = SDone;
        endcase
      end
      SClear: begin
        // The root comes out of the sweep as the only block on a list.
        mem_req_o.bits_waddr    = clr_cnt_q;
        mem_req_o.bits_we_split = 1'b1;
        mem_req_o.bits_we_onl   = 1'b1;
        mem_req_o.onl_wdata     = (clr_cnt_q[NodeW-1:0] == node_t'(1));
        mem_req_o.link_waddr    = clr_cnt_q;
        mem_req_o.link_we_prev  = (clr_cnt_q[NodeW-1:0] == node_t'(1));
        mem_req_o.link_we_next  = (clr_cnt_q[NodeW-1:0] == node_t'(1));
        clr_cnt_d = clr_cnt_q + MemAw'(1);
        if (clr_last) begin
          state_d = clr_all_q ? SIdle : SDone;
        end
      end
      SSplit: begin
        mem_req_o.bits_waddr    = {pool, node_q};
        mem_req_o.bits_we_split = 1'b1;
        mem_req_o.split_wdata   = 1'b1;
        cmd_node_d = node_q;
        cmd_lvl_d  = cl_q;
        cmd_push_d = 1'b0;
        ret_d      = (cl_q < lvl_q) ? SSplA : SAfin;
        state_d    = SR0;
      end
      SSplA: begin
        cmd_node_d = {node_q[NodeW-2:0], 1'b1};
        cmd_lvl_d  = cl_q + LvlW'(1);
        cmd_push_d = 1'b1;
        ret_d      = SSplB;
        state_d    = SR0;
      end
      SSplB: begin
        cmd_node_d = {node_q[NodeW-2:0], 1'b0};
        cmd_lvl_d  = cl_q + LvlW'(1);
        cmd_push_d = 1'b1;
        ret_d      = SSplC;
        state_d    = SR0;
      end
      SSplC: begin
        node_d  = {node_q[NodeW-2:0], 1'b0};
        cl_d    = cl_q + LvlW'(1);
        state_d = SSplit;
      end
      SAfin: begin
        baddr_d = base + blk_off;
        state_d = SDone;
      end
      SFrd: begin
        node_d            = free_node;
        mem_req_o.rd_addr = {pool, free_node};
        state_d           = SFchk;
      end
      SFchk: begin
        if (mem_rsp_i.split) begin
          mem_req_o.bits_waddr    = {pool, node_q};
          mem_req_o.bits_we_split = 1'b1;
          mem_req_o.split_wdata   = 1'b0;
          if (node_q != node_t'(1)) begin
            mem_req_o.rd_addr = {pool, buddy};
            state_d           = SFbud;
          end else begin
            cmd_node_d = node_q;
            cmd_lvl_d  = lvl_q;
            cmd_push_d = 1'b1;
            ret_d      = SDone;
            state_d    = SR0;
          end
        end else if (lvl_q == '0) begin
          state_d = SDone;
        end else begin
          lvl_d   = lvl_q - LvlW'(1);
          pos_d   = pos_q >> 1;
          state_d = SFrd;
        end
      end
      SFbud: begin
        cmd_lvl_d = lvl_q;
        state_d   = SR0;
        if (!mem_rsp_i.split) begin
          cmd_node_d = buddy;
          cmd_push_d = 1'b0;
          ret_d      = SFnext;
        end else begin
          cmd_node_d = node_q;
          cmd_push_d = 1'b1;
          ret_d      = SDone;
        end
      end
      SFnext: begin
        lvl_d   = lvl_q - LvlW'(1);
        pos_d   = pos_q >> 1;
        state_d = SFrd;
      end
      SR0: state_d = SR1;
      SR1: begin
        if (!mem_rsp_i.onl) begin
          state_d = cmd_push_q ? SP0 : ret_q;
        end else begin
          state_d = SR2;
        end
      end
      SR2: begin
        pv_d = mem_rsp_i.prev;
        nx_d = mem_rsp_i.next;
        mem_req_o.bits_we_onl = 1'b1;
        mem_req_o.onl_wdata   = 1'b0;
        if (mem_rsp_i.prev != '0) begin
          mem_req_o.link_waddr   = {pool, mem_rsp_i.prev};
          mem_req_o.link_we_next = 1'b1;
          mem_req_o.next_wdata   = mem_rsp_i.next;
        end else begin
          head_we    = 1'b1;
          head_wdata = mem_rsp_i.next;
        end
        state_d = SR3;
      end
      SR3: begin
        if (nx_q != '0) begin
          mem_req_o.link_waddr   = {pool, nx_q};
          mem_req_o.link_we_prev = 1'b1;
          mem_req_o.prev_wdata   = pv_q;
        end
        state_d = cmd_push_q ? SP0 : ret_q;
      end
      SP0: begin
        hd_d = cur_head;
        mem_req_o.link_we_prev = 1'b1;
        mem_req_o.link_we_next = 1'b1;
        mem_req_o.prev_wdata   = '0;
        mem_req_o.next_wdata   = cur_head;
        mem_req_o.bits_we_onl  = 1'b1;
        mem_req_o.onl_wdata    = 1'b1;
        head_we    = 1'b1;
        head_wdata = cmd_node_q;
        state_d    = (cur_head != '0) ? SP1 : ret_q;
      end
      SP1: begin
        mem_req_o.link_waddr   = {pool, hd_q};
        mem_req_o.link_we_prev = 1'b1;
        mem_req_o.prev_wdata   = cmd_node_q;
        state_d = ret_q;
      end
      SDone: begin
        done_o = 1'b1;
        if (out_free_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SClear;
      clr_cnt_q <= '0;
      clr_all_q <= 1'b1;
      for (int p = 0; p < 2; p++) begin
        for (int l = 0; l <= MaxHeight; l++) begin
          heads_q[p][l] <= (l == 0) ? node_t'(1) : '0;
        end
      end
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      clr_all_q <= clr_all_d;
      if (head_init) begin
        for (int l = 0; l <= MaxHeight; l++) begin
          heads_q[pool][l] <= (l == 0) ? node_t'(1) : '0;
        end
      end else if (head_we) begin
        heads_q[pool][head_lvl] <= head_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q      <= ret_d;
    item_q     <= item_d;
    node_q     <= node_d;
    cmd_node_q <= cmd_node_d;
    cmd_lvl_q  <= cmd_lvl_d;
    cmd_push_q <= cmd_push_d;
    nx_q       <= nx_d;
    pv_q       <= pv_d;
    hd_q       <= hd_d;
    cl_q       <= cl_d;
    lvl_q      <= lvl_d;
    pos_q      <= pos_d;
    status_q   <= status_d;
    baddr_q    <= baddr_d;
  end

  assign result_o.status        = status_q;
  assign result_o.block_address = baddr_q;

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate, free and reinitialize items into both pools under random
// idling on both channels and compares every result with a buddy predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import bba_pkg::*;

  localparam int WatchLimit = 20000;

  class alloc_scoreboard;
    bit          split_bit [2][2048];
    bit          listed    [2][2048];
    int unsigned next_blk  [2][2048];
    int unsigned prev_blk  [2][2048];
    int unsigned lvl_head  [2][MaxHeight+1];
    logic [31:0] pool_base [2];
    item_out_t   awaited [$];
    int          errors;
    int          checked;

    function void unlink(int p, int lvl, int unsigned n);
      int unsigned nx, pv;
      if (!listed[p][n]) return;
      nx = next_blk[p][n];
      pv = prev_blk[p][n];
      if (pv != 0) next_blk[p][pv] = nx;
      else lvl_head[p][lvl] = nx;
      if (nx != 0) prev_blk[p][nx] = pv;
      listed[p][n] = 0;
      next_blk[p][n] = 0;
      prev_blk[p][n] = 0;
    endfunction

    function void push_blk(int p, int lvl, int unsigned n);
      int unsigned hd;
      unlink(p, lvl, n);
      hd = lvl_head[p][lvl];
      next_blk[p][n] = hd;
      prev_blk[p][n] = 0;
      if (hd != 0) prev_blk[p][hd] = n;
      lvl_head[p][lvl] = n;
      listed[p][n] = 1;
    endfunction

    function void init_pool(int p);
      for (int i = 0; i < 2048; i++) begin
        split_bit[p][i] = 0;
        listed[p][i] = 0;
        next_blk[p][i] = 0;
        prev_blk[p][i] = 0;
      end
      for (int i = 0; i <= MaxHeight; i++) lvl_head[p][i] = 0;
      push_blk(p, 0, 1);
    endfunction

    function item_out_t predict(item_in_t it);
      item_out_t   r;
      int          p, h, pw, k, lvl, c, lv;
      int unsigned n, b, pos;
      logic [31:0] psize, sz, off;
      p = int'(it.pool);
      h = p ? LargeHeight : SmallHeight;
      pw = h + MinBlockLog;
      psize = 32'd1 << pw;
      r.status = StOk;
      r.block_address = '0;
      case (action_e'(it.action))
        ActAlloc: begin
          sz = {16'd0, it.request_size};
          if (sz == 0) begin
            r.status = StZeroSize;
          end else begin
            if (sz < (32'd1 << MinBlockLog)) sz = 32'd1 << MinBlockLog;
            if (sz > psize) begin
              r.status = StNoMem;
            end else begin
              k = MinBlockLog;
              while ((32'd1 << k) < sz) k++;
              lvl = pw - k;
              c = lvl;
              while (c >= 0 && lvl_head[p][c] == 0) c--;
              if (c < 0) begin
                r.status = StNoMem;
              end else begin
                n = lvl_head[p][c];
                while (c < lvl) begin
                  split_bit[p][n] = 1;
                  unlink(p, c, n);
                  push_blk(p, c + 1, 2 * n + 1);
                  push_blk(p, c + 1, 2 * n);
                  n = 2 * n;
                  c++;
                end
                split_bit[p][n] = 1;
                unlink(p, lvl, n);
                r.block_address = pool_base[p] + ((n - (1 << lvl)) << (pw - lvl));
              end
            end
          end
        end
        ActFree: begin
          if (it.address != 0) begin
            off = it.address - pool_base[p];
            if (it.address < pool_base[p] || off >= psize) begin
              r.status = StOutside;
            end else begin
              pos = off >> MinBlockLog;
              for (lv = h; lv >= 0; lv--) begin
                n = (1 << lv) + pos;
                if (split_bit[p][n]) begin
                  b = n ^ 1;
                  split_bit[p][n] = 0;
                  if (n != 1 && !split_bit[p][b]) begin
                    unlink(p, lv, b);
                    pos = pos >> 1;
                    continue;
                  end
                  push_blk(p, lv, n);
                  break;
                end
                pos = pos >> 1;
              end
            end
          end
        end
        ActInit: init_pool(p);
        default: ;
      endcase
      return r;
    endfunction

    function item_out_t note_input(item_in_t it);
      item_out_t r;
      r = predict(it);
      awaited.push_back(r);
      return r;
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(item_out_t got);
      item_out_t want;
      checked++;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result with nothing awaited, status %0d addr %h",
                                  got.status, got.block_address));
        return;
      end
      want = awaited[0];
      awaited.delete(0);
      if (got.status !== want.status)
        report_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                  checked, got.status, want.status));
      if (got.block_address !== want.block_address)
        report_mismatch($sformatf("result %0d address %h, predicted %h",
                                  checked, got.block_address, want.block_address));
    endtask
  endclass

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid_i = 0;
  logic      in_ready_o;
  item_in_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 0;
  item_out_t out_item_o;
  logic      cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  alloc_scoreboard sb = new();
  bit          calm;
  int          idle_cnt;
  int          n_alloc_ok, n_free, n_errs, n_init;
  int unsigned live_off [2][$];

  buddy_block_allocator u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 19);
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
  end

  // Any accepted item on either channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= WatchLimit) begin
      $display("watchdog expired with %0d results outstanding", sb.awaited.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_base(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.pool_base[idx] = val;
  endtask

  task automatic wait_drained();
    // The last item was already taken, so the sender lets go of valid.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_item(input item_in_t it);
    item_out_t r;
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 19) ? $urandom_range(1, 5) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    r = sb.note_input(it);
    case (action_e'(it.action))
      ActAlloc: if (r.status == StOk) begin
        n_alloc_ok++;
        live_off[it.pool].push_back(r.block_address - sb.pool_base[it.pool]);
      end
      ActFree: n_free++;
      ActInit: begin
        n_init++;
        live_off[it.pool].delete();
      end
      default: ;
    endcase
    if (r.status != StOk) n_errs++;
  endtask

  task automatic send_fields(input action_e act, input bit p, input logic [15:0] sz,
                             input logic [31:0] addr);
    item_in_t it;
    it.action = act;
    it.pool = p;
    it.request_size = sz;
    it.address = addr;
    send_item(it);
  endtask

  task automatic run_directed();
    for (int p = 0; p < 2; p++) begin
      send_fields(ActAlloc, 1'(p), 16'd0, $urandom);
      send_fields(ActAlloc, 1'(p), 16'd1, '0);
      send_fields(ActAlloc, 1'(p), 16'd33, '0);
      send_fields(ActAlloc, 1'(p), 16'hFFFF, '0);
      send_fields(ActFree, 1'(p), 16'($urandom), 32'd0);
      send_fields(ActFree, 1'(p), '0, sb.pool_base[p] - 32'd1);
      send_fields(ActFree, 1'(p), '0, sb.pool_base[p] + (32'd1 << (p ? 15 : 12)));
      // Unaligned free of the first block, then a double free of it.
      send_fields(ActFree, 1'(p), '0, sb.pool_base[p] + 32'd7);
      send_fields(ActFree, 1'(p), '0, sb.pool_base[p]);
      send_fields(ActFree, 1'(p), '0, sb.pool_base[p] + 32'd64);
      send_fields(ActNone, 1'(p), 16'($urandom), $urandom);
      send_fields(ActInit, 1'(p), '0, '0);
    end
  endtask

  task automatic run_random(input int count);
    item_in_t    it;
    int          r, p, sel;
    int unsigned span;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3 && i < count / 2);
      r = $urandom_range(0, 99);
      p = $urandom_range(0, 1);
      span = 32'd1 << (p ? 15 : 12);
      it.action = ActAlloc;
      it.pool = 1'(p);
      it.request_size = 16'($urandom);
      it.address = $urandom;
      if (r < 45) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) it.request_size = 16'($urandom_range(1, 256));
        else if (sel < 9) it.request_size = 16'($urandom_range(1, 4096));
      end else if (r < 82 && live_off[p].size() != 0) begin
        sel = $urandom_range(0, live_off[p].size() - 1);
        it.action = ActFree;
        it.address = sb.pool_base[p] + live_off[p][sel] +
                     (($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : 0);
        live_off[p].delete(sel);
      end else if (r < 82) begin
        it.request_size = 16'($urandom_range(1, 2048));
      end else if (r < 88) begin
        it.action = ActFree;
      end else if (r < 92) begin
        it.action = ActFree;
        it.address = sb.pool_base[p] + $urandom_range(0, span - 1);
      end else if (r < 94) begin
        it.action = ActInit;
      end else if (r < 96) begin
        it.action = ActNone;
      end else begin
        it.request_size = '0;
      end
      send_item(it);
    end
    calm = 0;
  endtask

  initial begin
    sb.pool_base[0] = '0;
    sb.pool_base[1] = '0;
    sb.init_pool(0);
    sb.init_pool(1);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_random(200);
    wait_drained();
    write_base(CfgSmallBase, 32'hFFFF_F000);
    write_base(CfgLargeBase, 32'hFFFF_8000);
    run_directed();
    run_random(200);
    wait_drained();
    write_base(CfgSmallBase, $urandom);
    write_base(CfgLargeBase, 32'hFFFF_FFFF);
    run_random(150);
    wait_drained();
    write_base(CfgSmallBase, 32'hFFFF_FFFF);
    write_base(CfgLargeBase, $urandom);
    run_random(150);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("covered %0d results: %0d allocations granted, %0d frees, %0d reinits,",
             sb.checked, n_alloc_ok, n_free, n_init);
    $display("%0d error statuses, across four pool base settings", n_errs);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_mem.sv
hw/rtl/bba_seq.sv
hw/rtl/buddy_block_allocator.sv
test/tb_top.sv
